@@ hw/rtl/rrb_pkg.sv @@
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared constants and types for the reorder and reassembly buffer.
// ----------------------------------------------------------------------------
`default_nettype none
package rrb_pkg;
    localparam int unsigned SLOTS       = 64;
    localparam int unsigned PAYLOAD_MAX = 256;
    localparam int unsigned SLOT_W      = $clog2(SLOTS);
    localparam int unsigned OFF_W       = $clog2(PAYLOAD_MAX);
    localparam int unsigned LEN_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int unsigned ADDR_W      = SLOT_W + OFF_W;

    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_MIDDLE = 2'd2,
        KIND_LAST   = 2'd3
    } kind_t;

    localparam logic REQ_RECV = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  kind;
        logic [LEN_W-1:0] len;
    } slot_meta_t;
endpackage
`default_nettype wire

@@ hw/rtl/rrb_payload_ram.sv @@
// ----------------------------------------------------------------------------
// rrb_payload_ram
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rrb_payload_ram (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [rrb_pkg::ADDR_W-1:0] waddr,
    input  wire logic [7:0]                wdata,
    input  wire logic                      re,
    input  wire logic [rrb_pkg::ADDR_W-1:0] raddr,
    output logic      [7:0]                rdata
);
    import rrb_pkg::*;
    logic [7:0] mem [SLOTS*PAYLOAD_MAX];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/rrb_meta_ram.sv @@
// ----------------------------------------------------------------------------
// rrb_meta_ram
// Slot descriptor store (id, kind, length): one write, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rrb_meta_ram (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [rrb_pkg::SLOT_W-1:0] waddr,
    input  wire rrb_pkg::slot_meta_t        wdata,
    input  wire logic [rrb_pkg::SLOT_W-1:0] raddr,
    output rrb_pkg::slot_meta_t             rdata
);
    import rrb_pkg::*;
    slot_meta_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/reorder_reassembly_buffer.sv @@
// ----------------------------------------------------------------------------
// reorder_reassembly_buffer
// Reorders packets by id and delivers complete messages byte by byte.
// ----------------------------------------------------------------------------
// Receive transaction: slot check and payload write, both in ST_RECV.
// Pull while a message is in progress: ST_RDM, then ST_RDP. A pull that starts
// a message checks the head slot in ST_SCAN and further fragments via ST_SCANW,
// up to SLOTS slots, then reads as above; with nothing ready it goes idle.
// Result strobe comes as the pull returns to idle; receiver cannot stall.
// Reset clears slot valid bits and control state; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module reorder_reassembly_buffer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [15:0] pkt_id,
    input  wire logic [1:0]  pkt_kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_last,
    output logic             strobe,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             msg_last
);
    import rrb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RECV  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_SCANW = 6'b001000,
        ST_RDM   = 6'b010000,
        ST_RDP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [15:0] last_id_reg, last_id_next;
    logic [LEN_W-1:0] woff_reg, woff_next;
    logic wdisc_reg, wdisc_next;
    logic [LEN_W-1:0] roff_reg, roff_next;
    logic ract_reg, ract_next;
    logic [15:0] rid_reg, rid_next;
    logic [15:0] scan_id_reg, scan_id_next;
    logic [SLOT_W:0] scan_cnt_reg, scan_cnt_next;
    logic [15:0] id_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic blast_reg;
    logic strobe_reg, strobe_next;
    logic ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic ml_reg, ml_next;

    logic meta_we;
    logic [SLOT_W-1:0] meta_waddr, meta_raddr;
    slot_meta_t meta_wdata, meta_rdata;
    logic pay_we, pay_re;
    logic [ADDR_W-1:0] pay_waddr, pay_raddr;
    logic [7:0] pay_rdata;

    rrb_meta_ram u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rdata)
    );
    rrb_payload_ram u_pay (
        .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(byte_reg),
        .re(pay_re), .raddr(pay_raddr), .rdata(pay_rdata)
    );

    logic accept;
    logic [15:0] id_ahead, head_id;
    logic [SLOT_W-1:0] in_slot, scan_slot, rd_slot;
    logic [LEN_W-1:0] rlen, roff_c, roff_inc;
    logic in_ok, scan_holds, scan_ready;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign head_id  = last_id_reg + 16'd1;
    assign in_slot  = id_reg[SLOT_W-1:0];
    assign id_ahead = id_reg - last_id_reg;
    assign in_ok    = (id_ahead != 16'd0) && (id_ahead <= 16'(SLOTS)) && !valid_reg[in_slot];
    assign scan_slot = scan_id_reg[SLOT_W-1:0];
    assign rd_slot  = rid_reg[SLOT_W-1:0];
    assign scan_holds = valid_reg[scan_slot] && (meta_rdata.id == scan_id_reg);
    assign scan_ready = scan_holds && ((scan_cnt_reg == '0 && meta_rdata.kind == KIND_FULL)
                        || (scan_cnt_reg != '0 && meta_rdata.kind == KIND_LAST));
    assign rlen     = (meta_rdata.len == '0 || meta_rdata.len > LEN_W'(PAYLOAD_MAX))
                      ? LEN_W'(1) : meta_rdata.len;
    assign roff_c   = (roff_reg >= rlen) ? rlen - LEN_W'(1) : roff_reg;
    assign roff_inc = roff_c + LEN_W'(1);

    always_comb
    begin
        meta_raddr = pkt_id[SLOT_W-1:0];
        unique case (state_reg)
            ST_IDLE:  meta_raddr = ract_reg ? rid_reg[SLOT_W-1:0] : head_id[SLOT_W-1:0];
            ST_SCAN:  meta_raddr = scan_ready ? head_id[SLOT_W-1:0] : scan_slot;
            ST_SCANW: meta_raddr = scan_slot;
            ST_RDM:   meta_raddr = rd_slot;
            ST_RDP:   meta_raddr = rd_slot;
            default:  meta_raddr = rd_slot;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        last_id_next  = last_id_reg;
        woff_next     = woff_reg;
        wdisc_next    = wdisc_reg;
        roff_next     = roff_reg;
        ract_next     = ract_reg;
        rid_next      = rid_reg;
        scan_id_next  = scan_id_reg;
        scan_cnt_next = scan_cnt_reg;
        strobe_next   = 1'b0;
        ov_next = 1'b0;
        ob_next = 8'd0;
        ml_next = 1'b0;
        meta_we = 1'b0;
        meta_waddr = in_slot;
        meta_wdata = '{id: id_reg, kind: kind_reg, len: woff_reg + LEN_W'(1)};
        pay_we = 1'b0;
        pay_waddr = {in_slot, woff_reg[OFF_W-1:0]};
        pay_re = 1'b0;
        pay_raddr = {rd_slot, roff_c[OFF_W-1:0]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_RECV)
                        state_next = ST_RECV;
                    else if (ract_reg)
                        state_next = ST_RDM;
                    else
                    begin
                        scan_id_next  = head_id;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_RECV:
            begin
                if (!wdisc_reg)
                begin
                    if (woff_reg >= LEN_W'(PAYLOAD_MAX) || !in_ok)
                        wdisc_next = 1'b1;
                    else
                    begin
                        pay_we = 1'b1;
                        woff_next = woff_reg + LEN_W'(1);
                        if (blast_reg)
                        begin
                            meta_we = 1'b1;
                            valid_next[in_slot] = 1'b1;
                        end
                    end
                end
                if (blast_reg)
                begin
                    woff_next  = '0;
                    wdisc_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!scan_holds)
                    state_next = ST_IDLE;
                else if (scan_cnt_reg == '0 && meta_rdata.kind == KIND_FULL)
                    state_next = ST_IDLE;
                else if (scan_cnt_reg == '0 && meta_rdata.kind != KIND_FIRST)
                    state_next = ST_IDLE;
                else if (scan_cnt_reg != '0 && meta_rdata.kind == KIND_LAST)
                    state_next = ST_IDLE;
                else if (scan_cnt_reg != '0 && meta_rdata.kind != KIND_MIDDLE)
                    state_next = ST_IDLE;
                else if (scan_cnt_reg == (SLOT_W+1)'(SLOTS - 1))
                    state_next = ST_IDLE;
                else
                begin
                    scan_id_next  = scan_id_reg + 16'd1;
                    scan_cnt_next = scan_cnt_reg + (SLOT_W+1)'(1);
                    state_next    = ST_SCANW;
                end
                if (scan_ready)
                begin
                    ract_next = 1'b1;
                    rid_next  = head_id;
                    roff_next = '0;
                    state_next = ST_RDM;
                end
                else if (state_next == ST_IDLE)
                    strobe_next = 1'b1;
            end
            ST_SCANW: state_next = ST_SCAN;
            ST_RDM:
            begin
                pay_re = 1'b1;
                roff_next = roff_inc;
                if (roff_inc >= rlen)
                begin
                    valid_next[rd_slot] = 1'b0;
                    last_id_next = rid_reg;
                    roff_next = '0;
                    if (meta_rdata.kind == KIND_FULL || meta_rdata.kind == KIND_LAST)
                    begin
                        ml_next = 1'b1;
                        ract_next = 1'b0;
                    end
                    else
                        rid_next = rid_reg + 16'd1;
                end
                state_next = ST_RDP;
            end
            ST_RDP:
            begin
                strobe_next = 1'b1;
                ov_next = 1'b1;
                ob_next = pay_rdata;
                ml_next = ml_reg;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            last_id_reg  <= 16'hFFFF;
            woff_reg     <= '0;
            wdisc_reg    <= 1'b0;
            roff_reg     <= '0;
            ract_reg     <= 1'b0;
            rid_reg      <= '0;
            scan_id_reg  <= '0;
            scan_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
            ov_reg <= 1'b0;
            ob_reg <= 8'd0;
            ml_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            last_id_reg  <= last_id_next;
            woff_reg     <= woff_next;
            wdisc_reg    <= wdisc_next;
            roff_reg     <= roff_next;
            ract_reg     <= ract_next;
            rid_reg      <= rid_next;
            scan_id_reg  <= scan_id_next;
            scan_cnt_reg <= scan_cnt_next;
            strobe_reg   <= strobe_next;
            ov_reg <= ov_next;
            ob_reg <= ob_next;
            ml_reg <= ml_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= pkt_id;
            kind_reg  <= pkt_kind;
            byte_reg  <= data_byte;
            blast_reg <= byte_last;
        end
    end

    assign strobe    = strobe_reg;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign msg_last  = ml_reg && ov_reg;

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> state_reg == ST_IDLE) else $error("strobe outside idle");
    a_valid_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> strobe_reg) else $error("data without strobe");
    a_rdp_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RDP |=> strobe_reg && ov_reg) else $error("missing byte");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ml_reg) |-> !ract_reg) else $error("read still active");
endmodule
`default_nettype wire

@@ tb/reorder_reassembly_buffer_test.sv @@
// ----------------------------------------------------------------------------
// reorder_reassembly_buffer_test
// Drives packet bytes and pull commands into the reorder and reassembly
// buffer and checks every delivered byte.
//
// Stimulus is mostly rounds of well-formed messages, whole or fragmented,
// sent out of order. Pulls are mixed in while packets are still arriving.
// Old, far, duplicate, oversized and id-changing packets are added as noise.
// A predictor inside the bench tracks the slots and the delivery state, and
// queues the expected result of every accepted pull. The monitor compares
// each strobed result against the oldest entry in that queue.
// ----------------------------------------------------------------------------
`default_nettype none
module reorder_reassembly_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrb_pkg::*;

    typedef struct {
        logic        req;
        logic [15:0] id;
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
        bit          drain;
    } txn_t;

    typedef struct {
        logic       vld;
        logic [7:0] data;
        logic       mlast;
    } dlv_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        req_type = 1'b0;
    logic [15:0] pkt_id = '0;
    logic [1:0]  pkt_kind = '0;
    logic [7:0]  data_byte = '0;
    logic        byte_last = 1'b0;
    logic        busy;
    logic        strobe;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        msg_last;

    reorder_reassembly_buffer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .pkt_id    (pkt_id),
        .pkt_kind  (pkt_kind),
        .data_byte (data_byte),
        .byte_last (byte_last),
        .strobe    (strobe),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .msg_last  (msg_last)
    );

    // reassembly state mirror
    bit          sl_vld [SLOTS];
    logic [15:0] sl_pid [SLOTS];
    kind_t       sl_knd [SLOTS];
    int unsigned sl_len [SLOTS];
    logic [7:0]  sl_mem [SLOTS*PAYLOAD_MAX];
    logic [15:0] delivered_id = 16'hFFFF;
    int unsigned wr_off = 0;
    bit          wr_drop = 0;
    int unsigned rd_off = 0;
    bit          rd_busy = 0;
    logic [15:0] rd_pid = '0;

    txn_t        send_q [$];
    dlv_t        dlv_q [$];
    txn_t        cur;
    int          gap_cnt = 0;
    int          n_items = 0;
    int          n_err = 0;
    int          n_bytes = 0;
    int          n_msgs = 0;
    int          n_idle = 0;
    bit          drain_set = 0;
    logic [15:0] gen_head = 16'hFFFF;

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned slot_of(logic [15:0] id);
        return id % SLOTS;
    endfunction

    function automatic bit in_window(logic [15:0] id);
        logic [15:0] d;
        d = id - delivered_id;
        return d != 0 && d <= SLOTS;
    endfunction

    function automatic bit holds_id(logic [15:0] id);
        return sl_vld[slot_of(id)] && sl_pid[slot_of(id)] == id;
    endfunction

    function automatic bit head_complete();
        logic [15:0] e;
        kind_t       k;
        e = delivered_id + 16'd1;
        if (!holds_id(e))
            return 0;
        k = sl_knd[slot_of(e)];
        if (k == KIND_FULL)
            return 1;
        if (k != KIND_FIRST)
            return 0;
        for (int j = 1; j < SLOTS; j++)
        begin
            if (!holds_id(e + 16'(j)))
                return 0;
            k = sl_knd[slot_of(e + 16'(j))];
            if (k == KIND_LAST)
                return 1;
            if (k != KIND_MIDDLE)
                return 0;
        end
        return 0;
    endfunction

    function automatic void store_byte(txn_t t);
        int unsigned s;
        s = slot_of(t.id);
        if (!wr_drop)
        begin
            if (wr_off >= PAYLOAD_MAX || !in_window(t.id) || sl_vld[s])
            begin
                wr_drop = 1;
            end
            else
            begin
                sl_mem[s*PAYLOAD_MAX + wr_off] = t.data;
                wr_off++;
                if (t.last)
                begin
                    sl_vld[s] = 1;
                    sl_pid[s] = t.id;
                    sl_knd[s] = t.kind;
                    sl_len[s] = wr_off;
                end
            end
        end
        if (t.last)
        begin
            wr_off = 0;
            wr_drop = 0;
        end
    endfunction

    function automatic dlv_t next_delivery();
        dlv_t        r;
        int unsigned s;
        int unsigned len;
        r = '{vld: 1'b0, data: 8'h00, mlast: 1'b0};
        if (!rd_busy)
        begin
            if (!head_complete())
                return r;
            rd_busy = 1;
            rd_pid = delivered_id + 16'd1;
            rd_off = 0;
        end
        s = slot_of(rd_pid);
        len = sl_len[s];
        if (len == 0 || len > PAYLOAD_MAX)
            len = 1;
        if (rd_off >= len)
            rd_off = len - 1;
        r.data = sl_mem[s*PAYLOAD_MAX + rd_off];
        r.vld = 1'b1;
        rd_off++;
        if (rd_off >= len)
        begin
            sl_vld[s] = 0;
            delivered_id = rd_pid;
            rd_off = 0;
            if (sl_knd[s] == KIND_FULL || sl_knd[s] == KIND_LAST)
            begin
                r.mlast = 1'b1;
                rd_busy = 0;
            end
            else
            begin
                rd_pid = rd_pid + 16'd1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (cur.req == REQ_PULL)
                    dlv_q.insert(dlv_q.size(), next_delivery());
                else
                    store_byte(cur);
            end
            if (!start || !busy)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    start <= 1'b0;
                end
                else if (send_q.size() > 0 && !(send_q[0].drain && dlv_q.size() > 0))
                begin
                    cur = send_q.pop_front();
                    start <= 1'b1;
                    req_type <= cur.req;
                    pkt_id <= cur.id;
                    pkt_kind <= cur.kind;
                    data_byte <= cur.data;
                    byte_last <= cur.last;
                    case ($urandom_range(0, 19))
                        0, 1, 2: gap_cnt = $urandom_range(1, 3);
                        3:       gap_cnt = $urandom_range(10, 40);
                        default: gap_cnt = 0;
                    endcase
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        dlv_t e;
        if (rst_n && strobe)
        begin
            if (dlv_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: valid %0b byte %02h last %0b",
                             out_valid, out_byte, msg_last);
            end
            else
            begin
                e = dlv_q.pop_front();
                if (out_valid !== e.vld || out_byte !== e.data || msg_last !== e.mlast)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp valid %0b byte %02h last %0b, got %0b %02h %0b",
                                 e.vld, e.data, e.mlast, out_valid, out_byte, msg_last);
                end
                if (e.vld) n_bytes++;
                else n_idle++;
                if (e.mlast) n_msgs++;
            end
        end
    end

    task automatic add_byte(logic req, logic [15:0] id, kind_t k, logic [7:0] b, logic l);
        send_q.insert(send_q.size(),
                      '{req: req, id: id, kind: k, data: b, last: l, drain: 0});
        n_items++;
    endtask

    task automatic add_pulls(int n);
        for (int i = 0; i < n; i++)
            add_byte(REQ_PULL, 16'($urandom), kind_t'($urandom_range(0, 3)), 8'($urandom),
                     1'($urandom));
    endtask

    task automatic add_packet(logic [15:0] id, kind_t k, int len);
        for (int i = 0; i < len; i++)
            add_byte(REQ_RECV, id, k, 8'($urandom), i == len - 1);
    endtask

    function automatic logic [15:0] outside_id();
        logic [15:0] id;
        logic [15:0] d;
        do
        begin
            id = 16'($urandom);
            d = id - gen_head;
        end while (d != 0 && d <= SLOTS + 16);
        return id;
    endfunction

    task automatic add_round();
        logic [15:0] pid [$];
        kind_t       pk [$];
        int          pl [$];
        int          ord [$];
        int          nm;
        int          nf;
        int          total;
        int          j;
        nm = $urandom_range(1, 4);
        total = 0;
        for (int m = 0; m < nm; m++)
        begin
            nf = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 4);
            for (int f = 0; f < nf; f++)
            begin
                pid.insert(pid.size(), gen_head + 16'(pid.size() + 1));
                if (nf == 1) pk.insert(pk.size(), KIND_FULL);
                else if (f == 0) pk.insert(pk.size(), KIND_FIRST);
                else if (f == nf - 1) pk.insert(pk.size(), KIND_LAST);
                else pk.insert(pk.size(), KIND_MIDDLE);
                pl.insert(pl.size(), ($urandom_range(0, 59) == 0)
                                     ? $urandom_range(200, PAYLOAD_MAX)
                                     : $urandom_range(1, 6));
                total += pl[$];
                ord.insert(ord.size(), pid.size() - 1);
            end
        end
        ord.shuffle();
        foreach (ord[i])
        begin
            j = ord[i];
            case ($urandom_range(0, 15))
                0: add_packet(outside_id(), kind_t'($urandom_range(0, 3)), $urandom_range(1, 4));
                1:
                begin
                    add_byte(REQ_RECV, pid[j], pk[j], 8'($urandom), 1'b0);
                    add_packet(outside_id(), pk[j], $urandom_range(1, 3));
                end
                2: if ($urandom_range(0, 3) == 0) add_packet(pid[j], pk[j], PAYLOAD_MAX + 1);
                3, 4: add_pulls($urandom_range(1, 3));
                default: ;
            endcase
            add_packet(pid[j], pk[j], pl[j]);
            if ($urandom_range(0, 15) == 0)
                add_packet(pid[j], pk[j], $urandom_range(1, 3));
        end
        add_pulls(total + $urandom_range(0, 2));
        gen_head = gen_head + 16'(pid.size());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // extremes: full packet, fragment pair, old id, far id
        add_byte(REQ_PULL, 16'h0000, KIND_FULL, 8'h00, 1'b0);
        add_byte(REQ_RECV, 16'h0000, KIND_FULL, 8'h00, 1'b1);
        add_byte(REQ_RECV, 16'h0002, KIND_LAST, 8'hFF, 1'b1);
        add_byte(REQ_RECV, 16'h0001, KIND_FIRST, 8'hFF, 1'b0);
        add_byte(REQ_RECV, 16'h0001, KIND_FIRST, 8'h5A, 1'b1);
        add_pulls(5);
        add_byte(REQ_RECV, 16'hFFFF, KIND_FULL, 8'hA5, 1'b1);
        add_byte(REQ_RECV, 16'h0043, KIND_FULL, 8'hA5, 1'b1);
        add_byte(REQ_RECV, 16'h0003, KIND_FIRST, 8'h11, 1'b1);
        add_byte(REQ_RECV, 16'h0004, KIND_MIDDLE, 8'h22, 1'b1);
        add_pulls(2);
        add_byte(REQ_RECV, 16'h0005, KIND_LAST, 8'h33, 1'b1);
        add_pulls(3);
        gen_head = 16'h0005;

        while (n_items < 1350)
        begin
            add_round();
            if (n_items > 600 && !drain_set)
            begin
                send_q[$].drain = 1;
                drain_set = 1;
            end
        end

        // stray middle fragment at the head blocks delivery
        add_packet(gen_head + 16'd1, KIND_MIDDLE, 2);
        add_pulls(3);

        wait (send_q.size() == 0 && !start);
        wait (dlv_q.size() == 0);
        repeat (300) @(posedge clk);
        $display("covered %0d transactions: %0d bytes in %0d messages delivered, %0d empty pulls",
                 n_items, n_bytes, n_msgs, n_idle);
        if (n_err == 0 && dlv_q.size() == 0)
            $display("reorder_reassembly_buffer_test: done, clean");
        else
            $display("reorder_reassembly_buffer_test: done, errors");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("timeout");
        $display("reorder_reassembly_buffer_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
